// File: design/ffgc_pkg.sv
// ----------------------------------------------------------------------------
// ffgc_pkg
// Shared types and constants of the first-fit graph coloring block.
// ----------------------------------------------------------------------------
package ffgc_pkg;

  // Fixed field widths of the request and result channels
  localparam int unsigned VERTEX_W     = 10;
  localparam int unsigned COLOR_W      = 8;
  localparam int unsigned OPCODE_W     = 2;
  localparam int unsigned VERTEX_SPAN  = 2 ** VERTEX_W;
  localparam int unsigned COLOR_SPAN   = 2 ** COLOR_W - 1;
  localparam int unsigned PALETTE_RST  = 255;

  // Colors examined per scan cycle
  localparam int unsigned MARK_CHUNK_W = 8;
  localparam int unsigned MARK_POS_W   = 3;

  typedef enum logic [OPCODE_W-1:0] {
    OP_NEIGHBOR = 2'd0,
    OP_FINISH   = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  // Control from the sequencer to the mark unit
  typedef struct packed {
    logic set;    // pending neighbor color is valid this cycle
    logic start;  // begin a first-fit scan
    logic wipe;   // clear all marks
  } mark_ctrl_t;

  // Status from the mark unit back to the sequencer
  typedef struct packed {
    logic done;   // scan finished this cycle
    logic found;  // a free color within the palette exists
  } scan_stat_t;

endpackage

// File: design/ffgc_color_mem.sv
// ----------------------------------------------------------------------------
// ffgc_color_mem
// Per-vertex color store: single-port-write, registered-read memory with a
// sweep that writes zero to every entry after reset and on request.
// ----------------------------------------------------------------------------
module ffgc_color_mem #(
  parameter int unsigned Depth  = 1024,
  parameter int unsigned AddrW  = 10,
  parameter int unsigned ColorW = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              sweep_start_i,
  output logic              sweep_busy_o,
  input  logic              rd_en_i,
  input  logic [AddrW-1:0]  rd_addr_i,
  output logic [ColorW-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [AddrW-1:0]  wr_addr_i,
  input  logic [ColorW-1:0] wr_data_i
);

  logic [ColorW-1:0] mem_q [Depth];
  logic [ColorW-1:0] rd_data_q;
  logic              busy_q, busy_d;
  logic [AddrW-1:0]  sweep_q, sweep_d;
  logic              we;
  logic [AddrW-1:0]  waddr;
  logic [ColorW-1:0] wdata;

  always_comb begin
    busy_d  = busy_q;
    sweep_d = sweep_q;
    if (sweep_start_i) begin
      busy_d  = 1'b1;
      sweep_d = '0;
    end else if (busy_q) begin
      sweep_d = sweep_q + AddrW'(1);
      if (sweep_q == AddrW'(Depth - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b1;
      sweep_q <= '0;
    end else begin
      busy_q  <= busy_d;
      sweep_q <= sweep_d;
    end
  end

  // Sweep owns the write port while busy
  assign we    = busy_q | wr_en_i;
  assign waddr = busy_q ? sweep_q : wr_addr_i;
  assign wdata = busy_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o    = rd_data_q;
  assign sweep_busy_o = busy_q;

endmodule

// File: design/ffgc_mark_scan.sv
// ----------------------------------------------------------------------------
// ffgc_mark_scan
// Used-color marks and the first-fit search over them, a chunk of colors
// per cycle from the lowest color up.
// ----------------------------------------------------------------------------
module ffgc_mark_scan
  import ffgc_pkg::*;
#(
  parameter int unsigned NumColors = 255,
  parameter int unsigned ColorW    = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mark_ctrl_t        ctrl_i,
  input  logic [ColorW-1:0] nbr_color_i,
  input  logic [ColorW-1:0] limit_i,
  output scan_stat_t        stat_o,
  output logic [ColorW-1:0] chosen_o
);

  localparam int unsigned NumChunks = (NumColors + MARK_CHUNK_W - 1) / MARK_CHUNK_W;
  localparam int unsigned MarkW     = NumChunks * MARK_CHUNK_W;
  localparam int unsigned CandW     = $clog2(MarkW + 1);

  logic [MarkW-1:0]        marks_q, marks_d;
  logic [CandW-1:0]        base_q, base_d;
  logic                    scanning_q, scanning_d;
  logic [MARK_CHUNK_W-1:0] chunk;
  logic [MARK_POS_W-1:0]   pos;
  logic                    hit;
  logic [CandW-1:0]        cand;
  logic [CandW-1:0]        next_base;
  logic [CandW-1:0]        limit_ext;
  logic                    in_palette;
  logic                    exhausted;
  logic                    done;

  assign chunk = marks_q[MARK_CHUNK_W-1:0];
  assign hit   = ~&chunk;

  // Lowest clear bit of the chunk
  always_comb begin
    pos = '0;
    for (int i = MARK_CHUNK_W - 1; i >= 0; i--) begin
      if (!chunk[i]) begin
        pos = MARK_POS_W'(i);
      end
    end
  end

  assign limit_ext  = CandW'(limit_i);
  assign cand       = base_q + CandW'(pos) + CandW'(1);
  assign next_base  = base_q + CandW'(MARK_CHUNK_W);
  assign in_palette = hit && (cand <= limit_ext);
  assign exhausted  = next_base >= limit_ext;
  assign done       = scanning_q && (hit || exhausted);

  always_comb begin
    marks_d    = marks_q;
    base_d     = base_q;
    scanning_d = scanning_q;
    if (ctrl_i.start) begin
      base_d     = '0;
      scanning_d = 1'b1;
    end else if (scanning_q) begin
      // advance to the next chunk of colors
      marks_d = marks_q >> MARK_CHUNK_W;
      base_d  = next_base;
      if (done) begin
        scanning_d = 1'b0;
      end
    end
    if (ctrl_i.set) begin
      for (int i = 0; i < MarkW; i++) begin
        if (CandW'(nbr_color_i) == CandW'(i + 1)) begin
          marks_d[i] = 1'b1;
        end
      end
    end
    if (ctrl_i.wipe) begin
      marks_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marks_q    <= '0;
      base_q     <= '0;
      scanning_q <= 1'b0;
    end else begin
      marks_q    <= marks_d;
      base_q     <= base_d;
      scanning_q <= scanning_d;
    end
  end

  assign stat_o.done  = done;
  assign stat_o.found = done && in_palette;
  assign chosen_o     = (done && in_palette) ? cand[ColorW-1:0] : '0;

endmodule

// File: design/first_fit_graph_coloring.sv
// ----------------------------------------------------------------------------
// first_fit_graph_coloring
// Greedy first-fit vertex coloring with an on-chip color store.
// ----------------------------------------------------------------------------
// Neighbor requests stream back to back: each does one read of the color
// store and sets a mark on the next cycle. A finish request searches the
// marks eight colors per cycle, then waits while the previous result is
// still held, and writes the chosen color to the color store (when one is
// found) and loads the result register. A clear request, and reset, start
// a sweep of the color store that writes one entry per cycle, during which
// no request is taken. Configuration writes of palette_limit are taken at
// any time.
// ----------------------------------------------------------------------------
module first_fit_graph_coloring
  import ffgc_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned MAX_COLORS   = 255
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [COLOR_W-1:0]  cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OPCODE_W-1:0] opcode_i,
  input  logic [VERTEX_W-1:0] vertex_i,
  input  logic [VERTEX_W-1:0] neighbor_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [VERTEX_W-1:0] colored_vertex_o,
  output logic [COLOR_W-1:0]  assigned_color_o,
  output logic [COLOR_W-1:0]  colors_used_o,
  output logic                no_free_color_o
);

  localparam int unsigned NumColors = (MAX_COLORS < COLOR_SPAN) ? MAX_COLORS : COLOR_SPAN;
  localparam int unsigned Depth     = (MAX_VERTICES < VERTEX_SPAN) ? MAX_VERTICES : VERTEX_SPAN;
  localparam int unsigned ColorW    = $clog2(NumColors + 1);
  localparam int unsigned AddrW     = $clog2(Depth);

  state_e              state_q, state_d;
  logic [COLOR_W-1:0]  palette_q;
  logic [ColorW-1:0]   limit_eff;
  logic [ColorW-1:0]   highest_q, highest_d;
  logic [VERTEX_W-1:0] vtx_q;
  logic [ColorW-1:0]   chosen_q;
  logic                nbr_pend_q, nbr_pend_d;

  logic                out_valid_q, out_valid_d;
  logic [VERTEX_W-1:0] out_vertex_q;
  logic [ColorW-1:0]   out_color_q;
  logic [ColorW-1:0]   out_used_q;
  logic                out_none_q;

  op_e                 op;
  logic                accept;
  logic                slot_free;
  logic                load;
  logic                nbr_ok;
  logic                vtx_ok;

  mark_ctrl_t          mark_ctrl;
  scan_stat_t          scan_stat;
  logic [ColorW-1:0]   scan_chosen;
  logic                sweep_start;
  logic                sweep_busy;
  logic                rd_en;
  logic [ColorW-1:0]   rd_data;
  logic                wr_en;

  assign op        = op_e'(opcode_i);
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept    = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign load      = (state_q == ST_EMIT) && slot_free;

  assign limit_eff = (32'(palette_q) > NumColors) ? ColorW'(NumColors) : ColorW'(palette_q);
  assign nbr_ok    = (neighbor_i != vertex_i) && (32'(neighbor_i) < Depth);
  assign vtx_ok    = 32'(vtx_q) < Depth;

  always_comb begin
    state_d     = state_q;
    nbr_pend_d  = 1'b0;
    highest_d   = highest_q;
    sweep_start = 1'b0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    mark_ctrl   = '0;
    mark_ctrl.set = nbr_pend_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (!sweep_busy) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_NEIGHBOR: begin
              rd_en      = 1'b1;
              nbr_pend_d = nbr_ok;
            end
            OP_FINISH: begin
              mark_ctrl.start = 1'b1;
              state_d         = ST_SCAN;
            end
            OP_CLEAR: begin
              mark_ctrl.wipe = 1'b1;
              sweep_start    = 1'b1;
              highest_d      = '0;
              state_d        = ST_CLEAR;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_stat.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hold until the result register can take the new result
        if (slot_free) begin
          wr_en          = (chosen_q != '0) && vtx_ok;
          mark_ctrl.wipe = 1'b1;
          if (chosen_q > highest_q) begin
            highest_d = chosen_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      palette_q   <= COLOR_W'(PALETTE_RST);
      highest_q   <= '0;
      nbr_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      highest_q   <= highest_d;
      nbr_pend_q  <= nbr_pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        palette_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (op == OP_FINISH)) begin
      vtx_q <= vertex_i;
    end
    if (scan_stat.done) begin
      chosen_q <= scan_chosen;
    end
    if (load) begin
      out_vertex_q <= vtx_q;
      out_color_q  <= chosen_q;
      out_used_q   <= highest_d;
      out_none_q   <= (chosen_q == '0);
    end
  end

  ffgc_color_mem #(
    .Depth  (Depth),
    .AddrW  (AddrW),
    .ColorW (ColorW)
  ) u_color_mem (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sweep_start_i (sweep_start),
    .sweep_busy_o  (sweep_busy),
    .rd_en_i       (rd_en),
    .rd_addr_i     (neighbor_i[AddrW-1:0]),
    .rd_data_o     (rd_data),
    .wr_en_i       (wr_en),
    .wr_addr_i     (vtx_q[AddrW-1:0]),
    .wr_data_i     (chosen_q)
  );

  ffgc_mark_scan #(
    .NumColors (NumColors),
    .ColorW    (ColorW)
  ) u_mark_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (mark_ctrl),
    .nbr_color_i (rd_data),
    .limit_i     (limit_eff),
    .stat_o      (scan_stat),
    .chosen_o    (scan_chosen)
  );

  assign out_valid_o      = out_valid_q;
  assign colored_vertex_o = out_vertex_q;
  assign assigned_color_o = COLOR_W'(out_color_q);
  assign colors_used_o    = COLOR_W'(out_used_q);
  assign no_free_color_o  = out_none_q;

`ifndef SYNTHESIS
  a_finish_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && opcode_i == OP_FINISH) |=> !in_ready_o)
    else $error("finish request did not stall the request channel");

  a_clear_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && opcode_i == OP_CLEAR) |=> (sweep_busy && !in_ready_o))
    else $error("clear request did not start the store sweep");

  a_flag_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (no_free_color_o == (assigned_color_o == '0)))
    else $error("no_free_color disagrees with assigned color");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (colors_used_o >= assigned_color_o))
    else $error("colors_used below assigned color");

  a_chosen_in_palette: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_stat.found |-> (scan_chosen != '0 && scan_chosen <= limit_eff))
    else $error("scan picked a color outside the palette");
`endif

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives first_fit_graph_coloring with vertex/neighbor request streams. A
// scoreboard keeps its own color store, used-color marks and top color, and
// checks every coloring result in order against its prediction.
// ----------------------------------------------------------------------------
module testbench;
  import ffgc_pkg::*;

  localparam int STUCK_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 40;
  localparam int STAIR_TOP = 24;

  typedef logic [VERTEX_W-1:0] vertex_t;
  typedef logic [COLOR_W-1:0]  color_t;

  typedef struct packed {
    vertex_t vertex;
    color_t  color;
    color_t  used;
    logic    none;
  } coloring_t;

  class first_fit_tracker;
    color_t            color_of [VERTEX_SPAN];
    vertex_t           rep_of [COLOR_SPAN+1];
    bit [COLOR_SPAN:1] taken;
    color_t            highest;
    color_t            palette;
    coloring_t         pending_colorings [$];
    int                mismatches;
    int                requests_seen;
    int                colorings_seen;
    int                exhausted_seen;
    int                top_color_seen;

    function new();
      wipe_colors();
      foreach (rep_of[i]) rep_of[i] = '0;
      palette = color_t'(PALETTE_RST);
      mismatches = 0;
      requests_seen = 0;
      colorings_seen = 0;
      exhausted_seen = 0;
      top_color_seen = 0;
    endfunction

    function void wipe_colors();
      foreach (color_of[i]) color_of[i] = '0;
      taken = '0;
      highest = '0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    // Note an accepted request and predict its coloring, if any.
    function void take_request(op_e op, vertex_t v, vertex_t n);
      int unsigned lim;
      int unsigned c;
      color_t pick;
      if (op != OP_NONE) requests_seen++;
      case (op)
        OP_NEIGHBOR: begin
          if (n != v && color_of[n] != 0) taken[color_of[n]] = 1'b1;
        end
        OP_FINISH: begin
          lim = palette;
          pick = '0;
          for (c = 1; c <= lim && pick == 0; c++) begin
            if (!taken[c]) pick = color_t'(c);
          end
          taken = '0;
          if (pick != 0) begin
            color_of[v] = pick;
            rep_of[pick] = v;
            if (pick > highest) highest = pick;
          end
          pending_colorings.push_back('{v, pick, highest, pick == 0});
        end
        OP_CLEAR: wipe_colors();
        default: ;
      endcase
    endfunction

    function void match_coloring(vertex_t v, color_t c, color_t u, logic f);
      coloring_t want;
      if (pending_colorings.size() == 0) begin
        flag($sformatf("unexpected coloring: vertex %0d color %0d used %0d none %0b",
                       v, c, u, f));
        return;
      end
      want = pending_colorings.pop_front();
      colorings_seen++;
      if (want.none) exhausted_seen++;
      if (int'(want.used) > top_color_seen) top_color_seen = int'(want.used);
      if (want.vertex !== v || want.color !== c || want.used !== u || want.none !== f)
        flag($sformatf({"coloring mismatch: vertex exp %0d got %0d, color exp %0d got %0d, ",
                        "used exp %0d got %0d, none exp %0b got %0b"},
                       want.vertex, v, want.color, c, want.used, u, want.none, f));
    endfunction
  endclass

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    cfg_we_i = 1'b0;
  color_t  cfg_wdata_i = '0;
  logic    in_valid_i = 1'b0;
  logic    in_ready_o;
  logic [OPCODE_W-1:0] opcode_i = OP_NEIGHBOR;
  vertex_t vertex_i = '0;
  vertex_t neighbor_i = '0;
  logic    out_valid_o;
  logic    out_ready_i = 1'b1;
  vertex_t colored_vertex_o;
  color_t  assigned_color_o;
  color_t  colors_used_o;
  logic    no_free_color_o;

  first_fit_tracker tracker = new();
  int idle_pct = 15;
  int ready_hold = 0;
  int stuck_cycles = 0;

  first_fit_graph_coloring i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .vertex_i        (vertex_i),
    .neighbor_i      (neighbor_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .colored_vertex_o(colored_vertex_o),
    .assigned_color_o(assigned_color_o),
    .colors_used_o   (colors_used_o),
    .no_free_color_o (no_free_color_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: check accepted colorings, stall in random bursts.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      tracker.match_coloring(colored_vertex_o, assigned_color_o, colors_used_o,
                             no_free_color_o);
    if (ready_hold != 0) ready_hold--;
    else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
      ready_hold = $urandom_range(1, 6);
    out_ready_i <= (ready_hold == 0);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STUCK_LIMIT);
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic vertex_t any_vertex();
    return vertex_t'($urandom_range(0, VERTEX_SPAN - 1));
  endfunction

  // Call at a rising edge; returns at the edge where the request is taken.
  task automatic send_request(op_e op, vertex_t v, vertex_t n);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    vertex_i   <= v;
    neighbor_i <= n;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.take_request(op, v, n);
  endtask

  task automatic send_noise(vertex_t v);
    case ($urandom_range(0, 2))
      0: send_request(OP_NEIGHBOR, v, v);
      1: send_request(OP_NEIGHBOR, v, any_vertex());
      default: send_request(OP_NONE, any_vertex(), any_vertex());
    endcase
  endtask

  // Stream neighbors holding colors 1..m (one maybe left out), then finish.
  // In grow mode m is the top color so far, which pushes the palette up.
  task automatic color_one_vertex(bit grow);
    vertex_t v;
    int top;
    int m;
    int skip;
    int start;
    int c;
    top = int'(tracker.highest);
    if (!grow && top > 0 && $urandom_range(0, 4) == 0)
      v = tracker.rep_of[$urandom_range(1, top)];
    else
      v = any_vertex();
    if (grow || $urandom_range(0, 3) == 0) m = top;
    else m = $urandom_range(0, top);
    skip = 0;
    if (!grow && m > 0 && $urandom_range(0, 2) == 0) skip = $urandom_range(1, m);
    start = (m > 0) ? $urandom_range(0, m - 1) : 0;
    for (int k = 0; k < m; k++) begin
      c = (start + k) % m + 1;
      if (!grow && $urandom_range(0, 7) == 0) send_noise(v);
      if (c != skip && int'(tracker.color_of[tracker.rep_of[c]]) == c)
        send_request(OP_NEIGHBOR, v, tracker.rep_of[c]);
    end
    // Now and then drop the finish, so marks carry into the next vertex.
    if (grow || $urandom_range(0, 19) != 0) send_request(OP_FINISH, v, any_vertex());
  endtask

  // Hold requests until every coloring is back, then let the block settle.
  task automatic await_colorings();
    in_valid_i <= 1'b0;
    while (tracker.pending_colorings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    // wait out a store sweep still running
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic set_palette(color_t limit);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.palette = limit;
  endtask

  task automatic run_phase(color_t limit, int items, int idle);
    int goal;
    await_colorings();
    set_palette(limit);
    idle_pct = idle;
    goal = tracker.requests_seen + items;
    while (tracker.requests_seen < goal) begin
      if ($urandom_range(0, 11) == 0) send_request(OP_CLEAR, any_vertex(), any_vertex());
      color_one_vertex(1'b0);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Palette at its reset value: basic chain, self and uncolored neighbors,
    // ignored opcode, recoloring, clear.
    send_request(OP_FINISH, 10'd0, 10'd1023);
    send_request(OP_NEIGHBOR, 10'd1, 10'd0);
    send_request(OP_NEIGHBOR, 10'd1, 10'd1);
    send_request(OP_NEIGHBOR, 10'd1, 10'd1023);
    send_request(OP_FINISH, 10'd1, 10'd0);
    send_request(OP_NONE, 10'd1023, 10'd1023);
    send_request(OP_NEIGHBOR, 10'd1023, 10'd0);
    send_request(OP_NEIGHBOR, 10'd1023, 10'd1);
    send_request(OP_FINISH, 10'd1023, 10'd1023);
    send_request(OP_FINISH, 10'd1, 10'd0);
    send_request(OP_NEIGHBOR, 10'd2, 10'd0);
    send_request(OP_NEIGHBOR, 10'd2, 10'd1023);
    send_request(OP_FINISH, 10'd2, 10'd0);
    send_request(OP_CLEAR, 10'd0, 10'd0);
    send_request(OP_NEIGHBOR, 10'd3, 10'd1023);
    send_request(OP_FINISH, 10'd3, 10'd0);
    // Single-color palette, then an empty one.
    await_colorings();
    set_palette(8'd1);
    send_request(OP_NEIGHBOR, 10'd4, 10'd3);
    send_request(OP_FINISH, 10'd4, 10'd0);
    send_request(OP_FINISH, 10'd5, 10'd0);
    await_colorings();
    set_palette(8'd0);
    send_request(OP_FINISH, 10'd6, 10'd0);

    // Build a staircase of colors across several scan chunks.
    await_colorings();
    set_palette(8'd255);
    send_request(OP_CLEAR, 10'd0, 10'd0);
    while (int'(tracker.highest) < STAIR_TOP) color_one_vertex(1'b1);

    run_phase(8'd20, 60, 15);
    run_phase(8'd24, 50, 0);
    run_phase(8'd25, 50, 25);
    run_phase(8'd1, 40, 15);
    run_phase(8'd0, 30, 15);
    run_phase(color_t'($urandom_range(2, 254)), 60, 15);
    run_phase(8'd8, 60, 30);
    run_phase(8'd255, 90, 0);
    await_colorings();

    $display("covered %0d requests and %0d colorings (%0d with no free color)",
             tracker.requests_seen, tracker.colorings_seen, tracker.exhausted_seen);
    $display("top color reached %0d, palette limits from 0 to 255",
             tracker.top_color_seen);
    if (tracker.mismatches == 0 && tracker.pending_colorings.size() == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

// File: sim.f
design/ffgc_pkg.sv
design/ffgc_color_mem.sv
design/ffgc_mark_scan.sv
design/first_fit_graph_coloring.sv
bench/testbench.sv
